@@ design/wpf_pkg.sv @@
// Shared types and constants for the waypoint path follower.
// No dependencies.
package wpf_pkg;

    localparam int MAX_WAYPOINTS = 64;
    localparam int FRAC_BITS     = 16;
    localparam int ADDR_W        = $clog2(MAX_WAYPOINTS);
    localparam int IDX_W         = 7;
    localparam int STEP_W        = 24;
    localparam int QUO_W         = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 23;
    localparam int WAIT_W        = 22;
    localparam int RAM_W         = 3 * 32 + WAIT_W;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_WRITE   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [16:0]        delta_time;
        logic               halt;
        logic [5:0]         wp_index;
        logic signed [31:0] wp_x;
        logic signed [31:0] wp_y;
        logic signed [31:0] wp_z;
        logic [WAIT_W-1:0]  wp_wait;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic [IDX_W-1:0]   target_index;
        logic               is_moving;
        logic               is_dwelling;
        logic               arrived;
    } t_out;

endpackage

@@ design/wpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/waypoint_path_follower_core.sv @@
// Waypoint path follower top level: sequencer, shared multiplier, sqrt and divide steps.
// Depends on wpf_pkg and wpf_ram.
//
//   channel | signals                          | direction
//   input   | i_in_valid / o_in_ready / i_req  | in
//   result  | o_out_valid / i_out_ready / o_rsp| out
//   config  | i_cfg_we / i_cfg_idx / i_cfg_data| in, write only
//
// A moving tick runs 32 square-root steps and three 24-step divides, one per axis,
// sharing one 32x32 multiplier. An arriving tick ends after the squared-distance check,
// a restart that loads waypoint 0 passes through S_RST_LD, and write, dwell and idle
// ticks go straight to S_OUT. One transaction at a time.
// Reset is synchronous, active low. A result waits in the output register while
// the next transaction is accepted; the sequencer stalls only to hand over a result.
module waypoint_path_follower_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  wpf_pkg::t_in                  i_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output wpf_pkg::t_out                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [wpf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wpf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RST_LD, S_TGT_LD, S_DIFF, S_SQ, S_SQRT,
        S_DMUL, S_DLD, S_DIV, S_DUPD, S_OUT
    } t_state;

    t_state r_state;

    logic [22:0]        r_speed;
    logic               r_loop;
    logic [IDX_W-1:0]   r_wcount;
    logic signed [31:0] r_pos [3];
    logic [IDX_W-1:0]   r_cur;
    logic signed [22:0] r_dwell;
    logic               r_moving;
    logic               r_arrived;
    t_in                r_in;
    logic signed [31:0] r_tgt [3];
    logic [WAIT_W-1:0]  r_wait;
    logic [32:0]        r_mag [3];
    logic [2:0]         r_neg;
    logic               r_big32, r_big31, r_far;
    logic [STEP_W-1:0]  r_step;
    logic [63:0]        r_sum;
    logic [63:0]        r_prod;
    logic [63:0]        r_rad;
    logic [35:0]        r_rem;
    logic [31:0]        r_root;
    logic [32:0]        r_drem;
    logic [QUO_W-1:0]   r_dq;
    logic [1:0]         r_ax;
    logic [4:0]         r_it;
    logic               r_ovalid;
    t_out               r_rsp;

    logic [IDX_W-1:0]   cnt;
    logic [31:0]        mul_a, mul_b;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [RAM_W-1:0]   ram_rdata;
    logic               in_acc;
    logic [STEP_W-1:0]  step_now;
    logic signed [32:0] diff;
    logic [32:0]        mag_now;
    logic [1:0]         shamt;
    logic [30:0]        mag_s;
    logic [35:0]        sq_t, sq_trial;
    logic [32:0]        dv_t;
    logic signed [33:0] upd;
    logic [IDX_W-1:0]   cur_inc;

    assign cnt       = (r_wcount > IDX_W'(MAX_WAYPOINTS)) ? IDX_W'(MAX_WAYPOINTS) : r_wcount;
    assign in_acc    = i_in_valid && o_in_ready;
    assign ram_we    = in_acc && (i_req.req_type == REQ_WRITE)
                       && ({1'b0, i_req.wp_index} < 7'(MAX_WAYPOINTS));
    assign ram_raddr = (i_req.req_type == REQ_RESTART) ? '0 : r_cur[ADDR_W-1:0];

    wpf_ram #(.WIDTH(RAM_W), .DEPTH(MAX_WAYPOINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.wp_index[ADDR_W-1:0]),
        .i_wdata ({i_req.wp_x, i_req.wp_y, i_req.wp_z, i_req.wp_wait}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign step_now = r_prod[FRAC_BITS +: STEP_W];
    assign diff     = 33'(r_tgt[r_ax]) - 33'(r_pos[r_ax]);
    assign mag_now  = diff[32] ? 33'(-diff) : 33'(diff);
    assign shamt    = r_big32 ? 2'd2 : (r_big31 ? 2'd1 : 2'd0);
    assign mag_s    = 31'(r_mag[r_ax] >> shamt);
    assign sq_t     = {r_rem[33:0], r_rad[63:62]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign dv_t     = {r_drem[31:0], r_dq[QUO_W-1]};
    assign upd      = r_neg[r_ax] ? (34'(r_pos[r_ax]) - 34'(r_dq))
                                  : (34'(r_pos[r_ax]) + 34'(r_dq));
    assign cur_inc  = r_cur + 1'b1;

    always_comb begin
        mul_a = {9'd0, r_speed};
        mul_b = {15'd0, r_in.delta_time};
        case (r_state)
            S_SQ: begin
                if (r_it == 5'd3) begin
                    mul_a = 32'(r_step);
                    mul_b = 32'(r_step);
                end else begin
                    mul_a = 32'(mag_s);
                    mul_b = 32'(mag_s);
                end
            end
            S_DMUL: begin
                mul_a = 32'(mag_s);
                mul_b = 32'(r_step);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_speed   <= 23'd327680;
            r_loop    <= 1'b0;
            r_wcount  <= '0;
            r_pos     <= '{default: '0};
            r_cur     <= '0;
            r_dwell   <= '0;
            r_moving  <= 1'b1;
            r_arrived <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPEED: r_speed  <= i_cfg_data;
                    CFG_LOOP:  r_loop   <= i_cfg_data[0];
                    CFG_COUNT: r_wcount <= i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            if ((r_state == S_OUT) && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in      <= i_req;
                        r_arrived <= 1'b0;
                        case (i_req.req_type)
                            REQ_TICK: begin
                                if (r_moving && !i_req.halt && (r_cur < cnt)) begin
                                    if (r_dwell > 0) begin
                                        r_dwell <= r_dwell - $signed({6'd0, i_req.delta_time});
                                        r_state <= S_OUT;
                                    end else begin
                                        r_state <= S_TGT_LD;
                                    end
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            REQ_RESTART: begin
                                r_cur    <= '0;
                                r_dwell  <= '0;
                                r_moving <= 1'b1;
                                r_state  <= (cnt != '0) ? S_RST_LD : S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_RST_LD: begin
                    r_pos[0] <= ram_rdata[RAM_W-1 -: 32];
                    r_pos[1] <= ram_rdata[RAM_W-33 -: 32];
                    r_pos[2] <= ram_rdata[RAM_W-65 -: 32];
                    r_state  <= S_OUT;
                end
                S_TGT_LD: begin
                    r_tgt[0] <= ram_rdata[RAM_W-1 -: 32];
                    r_tgt[1] <= ram_rdata[RAM_W-33 -: 32];
                    r_tgt[2] <= ram_rdata[RAM_W-65 -: 32];
                    r_wait   <= ram_rdata[WAIT_W-1:0];
                    r_big32  <= 1'b0;
                    r_big31  <= 1'b0;
                    r_far    <= 1'b0;
                    r_ax     <= '0;
                    r_state  <= S_DIFF;
                end
                S_DIFF: begin
                    r_step       <= step_now;
                    r_mag[r_ax]  <= mag_now;
                    r_neg[r_ax]  <= diff[32];
                    r_big32      <= r_big32 | mag_now[32];
                    r_big31      <= r_big31 | mag_now[31];
                    r_far        <= r_far | (mag_now > 33'(step_now));
                    r_ax         <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
                    if (r_ax == 2'd2) begin
                        r_it    <= '0;
                        r_sum   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_it < 5'd2) begin
                        r_ax <= r_ax + 1'b1;
                    end
                    if (r_it >= 5'd1 && r_it <= 5'd3) begin
                        r_sum <= r_sum + r_prod;
                    end
                    if (r_it == 5'd4) begin
                        if (!r_far && (r_sum <= r_prod)) begin
                            r_pos[0]  <= r_tgt[0];
                            r_pos[1]  <= r_tgt[1];
                            r_pos[2]  <= r_tgt[2];
                            r_dwell   <= $signed({1'b0, r_wait});
                            r_arrived <= 1'b1;
                            if (cur_inc >= cnt) begin
                                if (r_loop) begin
                                    r_cur <= '0;
                                end else begin
                                    r_cur    <= cur_inc;
                                    r_moving <= 1'b0;
                                end
                            end else begin
                                r_cur <= cur_inc;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_rad   <= r_sum;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_it    <= 5'd31;
                            r_state <= S_SQRT;
                        end
                    end else begin
                        r_it <= r_it + 1'b1;
                    end
                end
                S_SQRT: begin
                    r_rad <= {r_rad[61:0], 2'b00};
                    if (sq_t >= sq_trial) begin
                        r_rem  <= sq_t - sq_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= sq_t;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_it <= r_it - 1'b1;
                    if (r_it == '0) begin
                        r_ax    <= '0;
                        r_state <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    r_state <= (r_root == '0) ? S_OUT : S_DLD;
                end
                S_DLD: begin
                    r_drem  <= r_prod[QUO_W +: 33];
                    r_dq    <= r_prod[QUO_W-1:0];
                    r_it    <= 5'(QUO_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dv_t >= {1'b0, r_root}) begin
                        r_drem <= dv_t - {1'b0, r_root};
                        r_dq   <= {r_dq[QUO_W-2:0], 1'b1};
                    end else begin
                        r_drem <= dv_t;
                        r_dq   <= {r_dq[QUO_W-2:0], 1'b0};
                    end
                    r_it <= r_it - 1'b1;
                    if (r_it == '0) begin
                        r_state <= S_DUPD;
                    end
                end
                S_DUPD: begin
                    if (upd > 34'sh07FFFFFFF) begin
                        r_pos[r_ax] <= 32'sh7FFFFFFF;
                    end else if (upd < -34'sh080000000) begin
                        r_pos[r_ax] <= 32'sh80000000;
                    end else begin
                        r_pos[r_ax] <= upd[31:0];
                    end
                    r_ax    <= r_ax + 1'b1;
                    r_state <= (r_ax == 2'd2) ? S_OUT : S_DMUL;
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_rsp.out_pos_x    <= r_pos[0];
                        r_rsp.out_pos_y    <= r_pos[1];
                        r_rsp.out_pos_z    <= r_pos[2];
                        r_rsp.target_index <= r_cur;
                        r_rsp.is_moving    <= r_moving;
                        r_rsp.is_dwelling  <= (r_dwell > 0);
                        r_rsp.arrived      <= r_arrived;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_rsp       = r_rsp;
endmodule

@@ design/wpf_checker.sv @@
// Port-level checks for the waypoint path follower, bound to the top level.
// Depends on wpf_pkg and waypoint_path_follower_core.
module wpf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input wpf_pkg::t_in                   i_req,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input wpf_pkg::t_out                  o_rsp,
    input logic                           i_cfg_we,
    input logic [wpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [wpf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wpf_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a transaction");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_rsp.target_index <= IDX_W'(MAX_WAYPOINTS))
        else $error("target index out of range");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind waypoint_path_follower_core wpf_checker u_wpf_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for waypoint_path_follower_core: directed table, then random phases.
// Depends on wpf_pkg; predicts results with a local model or takes them from the table.
module testbench;
    import wpf_pkg::*;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        int                   cfg_val;
        t_in                  req;
        bit                   typed;
        t_out                 exp;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   i_req = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_rsp;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic signed [31:0] wp_x_tbl [MAX_WAYPOINTS];
    logic signed [31:0] wp_y_tbl [MAX_WAYPOINTS];
    logic signed [31:0] wp_z_tbl [MAX_WAYPOINTS];
    logic [WAIT_W-1:0]  wp_wait_tbl [MAX_WAYPOINTS];
    logic signed [31:0] cur_pos [3];
    int                 cur_wp;
    int                 dwell_left;
    bit                 moving;
    logic [22:0]        speed_q16;
    bit                 loop_on;
    logic [6:0]         wp_count;

    t_out follower_state_q [$];
    int   mismatches = 0;
    bit   quiet = 0;
    int   stall_left = 0;
    t_row dir_rows [$];

    waypoint_path_follower_core dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(longint signed v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic bit advance_tick(logic [16:0] dt);
        int                 cnt;
        logic signed [31:0] tgt [3];
        longint signed      d [3];
        longint unsigned    mag [3];
        longint unsigned    step, acc, maxmag, sum, span, mv;
        int                 s;
        bit                 arr;
        cnt = (wp_count > MAX_WAYPOINTS) ? MAX_WAYPOINTS : wp_count;
        if (cur_wp >= cnt) return 0;
        if (dwell_left > 0) begin
            dwell_left -= dt;
            return 0;
        end
        tgt[0] = wp_x_tbl[cur_wp];
        tgt[1] = wp_y_tbl[cur_wp];
        tgt[2] = wp_z_tbl[cur_wp];
        step = (longint'(speed_q16) * longint'(dt)) >> FRAC_BITS;
        acc = 0;
        maxmag = 0;
        arr = 1;
        for (int a = 0; a < 3; a++) begin
            d[a] = longint'(tgt[a]) - longint'(cur_pos[a]);
            mag[a] = (d[a] < 0) ? -d[a] : d[a];
            if (mag[a] > maxmag) maxmag = mag[a];
            if (mag[a] > step) arr = 0;
            else acc += mag[a] * mag[a];
        end
        if (arr && acc > step * step) arr = 0;
        if (arr) begin
            for (int a = 0; a < 3; a++) cur_pos[a] = tgt[a];
            dwell_left = int'(wp_wait_tbl[cur_wp]);
            cur_wp++;
            if (cur_wp >= cnt) begin
                if (loop_on) cur_wp = 0;
                else moving = 0;
            end
            return 1;
        end
        s = (maxmag >= (64'd1 << 32)) ? 2 : ((maxmag >= (64'd1 << 31)) ? 1 : 0);
        sum = 0;
        for (int a = 0; a < 3; a++) sum += (mag[a] >> s) * (mag[a] >> s);
        span = int_sqrt(sum);
        if (span == 0) return 0;
        for (int a = 0; a < 3; a++) begin
            mv = ((mag[a] >> s) * step) / span;
            cur_pos[a] = clamp32(longint'(cur_pos[a]) +
                                 ((d[a] < 0) ? -longint'(mv) : longint'(mv)));
        end
        return 0;
    endfunction

    function automatic t_out predict_state(t_in r);
        t_out o;
        bit   arr;
        arr = 0;
        case (r.req_type)
            REQ_TICK: begin
                if (moving && !r.halt) arr = advance_tick(r.delta_time);
            end
            REQ_WRITE: begin
                wp_x_tbl[r.wp_index] = r.wp_x;
                wp_y_tbl[r.wp_index] = r.wp_y;
                wp_z_tbl[r.wp_index] = r.wp_z;
                wp_wait_tbl[r.wp_index] = r.wp_wait;
            end
            REQ_RESTART: begin
                cur_wp = 0;
                dwell_left = 0;
                moving = 1;
                if (wp_count != 0) begin
                    cur_pos[0] = wp_x_tbl[0];
                    cur_pos[1] = wp_y_tbl[0];
                    cur_pos[2] = wp_z_tbl[0];
                end
            end
            default: ;
        endcase
        o.out_pos_x = cur_pos[0];
        o.out_pos_y = cur_pos[1];
        o.out_pos_z = cur_pos[2];
        o.target_index = IDX_W'(cur_wp);
        o.is_moving = moving;
        o.is_dwelling = dwell_left > 0;
        o.arrived = arr;
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // hold valid across back-to-back transactions, drop it only for a gap
    task automatic send_item(t_in r, bit typed, t_out exp);
        int   gap;
        t_out p;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_in_ready);
        p = predict_state(r);
        follower_state_q = {follower_state_q, (typed ? exp : p)};
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (follower_state_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SPEED: speed_q16 = 23'(val);
            CFG_LOOP:  loop_on = val[0];
            CFG_COUNT: wp_count = 7'(val);
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h400000)) - 32'sh200000;
    endfunction

    function automatic t_in rand_item(bit only_write);
        t_in r;
        int  p;
        r = '0;
        r.delta_time = 17'($urandom);
        r.wp_index = 6'($urandom);
        r.wp_x = rand_coord();
        r.wp_y = rand_coord();
        r.wp_z = rand_coord();
        p = $urandom_range(0, 9);
        r.wp_wait = WAIT_W'((p < 3) ? 0 : (p < 9) ? $urandom_range(0, 131072)
                                                  : $urandom_range(0, 3932160));
        p = $urandom_range(0, 99);
        r.req_type = only_write ? REQ_WRITE : (p < 78) ? REQ_TICK : (p < 88) ? REQ_WRITE
                                : (p < 96) ? REQ_RESTART : 2'd3;
        r.halt = ($urandom_range(0, 9) == 0);
        p = $urandom_range(0, 9);
        r.delta_time = (p == 0) ? 17'd65536 : (p == 1) ? 17'd0
                     : (p < 4) ? 17'($urandom_range(0, 4096))
                               : 17'($urandom_range(0, 65536));
        return r;
    endfunction

    function automatic t_out st(logic signed [31:0] x, logic signed [31:0] y,
                                logic signed [31:0] z, int idx, bit mv, bit dw, bit ar);
        t_out o;
        o.out_pos_x = x;
        o.out_pos_y = y;
        o.out_pos_z = z;
        o.target_index = IDX_W'(idx);
        o.is_moving = mv;
        o.is_dwelling = dw;
        o.arrived = ar;
        return o;
    endfunction

    task automatic add_row(bit is_cfg, logic [CFG_IDX_W-1:0] ci, int cv, logic [1:0] kind,
                           logic [16:0] dt, bit halt, int idx, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z, int wt,
                           bit typed, t_out exp);
        t_row row;
        row.is_cfg = is_cfg;
        row.cfg_idx = ci;
        row.cfg_val = cv;
        row.req = '0;
        row.req.req_type = kind;
        row.req.delta_time = dt;
        row.req.halt = halt;
        row.req.wp_index = 6'(idx);
        row.req.wp_x = x;
        row.req.wp_y = y;
        row.req.wp_z = z;
        row.req.wp_wait = WAIT_W'(wt);
        row.typed = typed;
        row.exp = exp;
        dir_rows = {dir_rows, row};
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (follower_state_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_rsp);
            end else begin
                t_out e;
                e = follower_state_q.pop_front();
                if (o_rsp.out_pos_x !== e.out_pos_x || o_rsp.out_pos_y !== e.out_pos_y ||
                    o_rsp.out_pos_z !== e.out_pos_z ||
                    o_rsp.target_index !== e.target_index ||
                    o_rsp.is_moving !== e.is_moving || o_rsp.is_dwelling !== e.is_dwelling ||
                    o_rsp.arrived !== e.arrived) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", e, o_rsp);
                end
            end
        end
        if (!i_rst_n || quiet) begin
            i_out_ready <= i_rst_n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0:       stall_left <= $urandom_range(10, 50);
                1, 2, 3: stall_left <= $urandom_range(0, 3);
                default: stall_left <= 0;
            endcase
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_out z;
        t_out none;
        none = '0;
        cur_pos[0] = 0;
        cur_pos[1] = 0;
        cur_pos[2] = 0;
        cur_wp = 0;
        dwell_left = 0;
        moving = 1;
        speed_q16 = 23'd327680;
        loop_on = 0;
        wp_count = 0;
        z = st(0, 0, 0, 0, 1, 0, 0);

        add_row(0, 0, 0, REQ_TICK, 17'd65536, 0, 0, 0, 0, 0, 0, 1, z);
        add_row(0, 0, 0, REQ_TICK, 17'd0, 1, 0, 0, 0, 0, 0, 1, z);
        add_row(0, 0, 0, 2'd3, 17'd65536, 1, 63, -1, -1, -1, 3932160, 1, z);
        add_row(0, 0, 0, REQ_WRITE, 0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 3932160, 1, z);
        add_row(0, 0, 0, REQ_WRITE, 0, 0, 63, 32'sh7FFFFFFF, 32'sh80000000, -1, 0, 1, z);
        add_row(0, 0, 0, REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 1, z);
        add_row(0, 0, 0, REQ_WRITE, 0, 0, 1, 65536, -65536, 131072, 65536, 1, z);
        add_row(1, CFG_COUNT, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(1, CFG_SPEED, 6553600, 0, 0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 1,
                st(32'sh80000000, 32'sh7FFFFFFF, 0, 0, 1, 0, 0));
        add_row(0, 0, 0, REQ_TICK, 17'd65536, 0, 0, 0, 0, 0, 0, 1,
                st(32'sh80000000, 32'sh7FFFFFFF, 0, 1, 1, 1, 1));
        add_row(0, 0, 0, REQ_TICK, 17'd65536, 1, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_TICK, 17'd65536, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_WRITE, 0, 0, 0, 0, 0, 0, 65536, 0, none);
        add_row(0, 0, 0, REQ_WRITE, 0, 0, 1, 1000000, -300000, 50000, 0, 0, none);
        add_row(1, CFG_LOOP, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_TICK, 17'd0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_TICK, 17'd65536, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_TICK, 17'd65536, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_TICK, 17'd65536, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(1, CFG_SPEED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, 0, REQ_TICK, 17'd65536, 0, 0, 0, 0, 0, 0, 0, none);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) write_reg(dir_rows[k].cfg_idx, dir_rows[k].cfg_val);
            else send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].exp);
        end

        // fill the whole table so any count is safe to use
        for (int w = 0; w < MAX_WAYPOINTS; w++) begin
            t_in r;
            r = rand_item(1);
            r.wp_index = 6'(w);
            send_item(r, 0, none);
        end

        for (int ph = 0; ph < 12; ph++) begin
            quiet = (ph % 4 == 3);
            case (ph)
                0:       write_reg(CFG_SPEED, 6553600);
                1:       write_reg(CFG_SPEED, 0);
                2:       write_reg(CFG_SPEED, 327680);
                default: write_reg(CFG_SPEED, ($urandom_range(0, 3) == 0) ?
                                   $urandom_range(0, 6553600) : $urandom_range(65536, 1310720));
            endcase
            write_reg(CFG_LOOP, ph % 2);
            case (ph)
                0:       write_reg(CFG_COUNT, 127);
                1:       write_reg(CFG_COUNT, 64);
                2:       write_reg(CFG_COUNT, 0);
                3:       write_reg(CFG_COUNT, 1);
                default: write_reg(CFG_COUNT, $urandom_range(2, 8));
            endcase
            for (int n = 0; n < 105; n++) begin
                t_in r;
                r = rand_item(0);
                if (n == 0) r.req_type = REQ_RESTART;
                send_item(r, 0, none);
            end
        end

        i_in_valid <= 1'b0;
        while (follower_state_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && follower_state_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
